>>> src/assert_macros.svh
// Assertion helper macros for the 3x3 filter RTL.
// Self-contained; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("next-cycle implication failed");

`endif

>>> src/c3f_pkg.sv
// Shared types and constants for the 3x3 clamped convolution filter.
// No dependencies; imported by the filter datapath and the top level.
package c3f_pkg;

    // Pixel and coefficient geometry
    localparam int PIX_W      = 8;
    localparam int CH_N       = 3;
    localparam int PIX_PACK_W = PIX_W * CH_N;
    localparam int TAPS       = 9;
    localparam int COEF_W     = 12;
    localparam int MASK_W     = 3 * COEF_W;
    localparam int BIAS_W     = 9;
    localparam int PIX_MAX    = 255;

    // Frame geometry
    localparam int DIM_W     = 12;
    localparam int POS_W     = 11;
    localparam int MIN_DIM   = 3;
    localparam int ROW_LIMIT = 2048;

    // Stream beat layout
    localparam int IN_DATA_W  = PIX_PACK_W;
    localparam int OUT_USED_W = PIX_PACK_W + 2 * POS_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = MASK_W;

    localparam logic [MASK_W-1:0] MASK_MID_RESET = MASK_W'(36'h0_0008_0000);
    localparam logic [DIM_W-1:0]  WIDTH_RESET    = DIM_W'(640);
    localparam logic [DIM_W-1:0]  HEIGHT_RESET   = DIM_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASK_TOP    = 3'd0,
        CFG_MASK_MIDDLE = 3'd1,
        CFG_MASK_BOTTOM = 3'd2,
        CFG_OFFSET_BIAS = 3'd3,
        CFG_FRAME_WIDTH = 3'd4,
        CFG_FRAME_HEIGHT = 3'd5,
        CFG_COLOUR_MODE = 3'd6
    } cfg_reg_t;

    // Per-pixel position info carried down the pipeline
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } pos_info_t;

endpackage

>>> src/c3f_line_buf.sv
// Dual line store: one write port, one registered read port, with
// write-to-read bypass for a same-address access. No package dependency.
module c3f_line_buf #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 48
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_q_reg;
    logic [DATA_W-1:0] byp_data_reg;
    logic              byp_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; a write to the same entry on the same edge wins
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg     <= mem[rd_addr];
            byp_reg      <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_q_reg;

endmodule

>>> src/c3f_mac.sv
// One channel of the 3x3 weighted sum: nine products, bias, truncate, clamp.
// Depends on c3f_pkg for pixel, coefficient and bias widths.
module c3f_mac import c3f_pkg::*; #(
    parameter int FRAC_BITS = 7
) (
    input  logic [TAPS-1:0][PIX_W-1:0]  taps,
    input  logic [TAPS-1:0][COEF_W-1:0] coefs,
    input  logic [BIAS_W-1:0]           bias,
    output logic [PIX_W-1:0]            res
);

    localparam int PROD_W    = PIX_W + COEF_W + 1;
    localparam int SUM_W     = PROD_W + 4;
    localparam int BIAS_SH_W = BIAS_W + FRAC_BITS;
    localparam int ACC_W     = ((SUM_W > BIAS_SH_W) ? SUM_W : BIAS_SH_W) + 1;

    logic signed [PROD_W-1:0] prod [TAPS];
    logic signed [ACC_W-1:0]  acc;
    logic        [ACC_W-1:0]  quo;

    // Products: unsigned pixel times signed coefficient
    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            prod[i] = PROD_W'($signed({1'b0, taps[i]})) * PROD_W'($signed(coefs[i]));
        end
    end

    // Exact sum with the bias scaled to the coefficient fraction
    always_comb begin
        acc = {{(ACC_W-BIAS_W){bias[BIAS_W-1]}}, bias} << FRAC_BITS;
        for (int i = 0; i < TAPS; i++) begin
            acc = acc + {{(ACC_W-PROD_W){prod[i][PROD_W-1]}}, prod[i]};
        end
    end

    // Non-positive gives zero, else drop fraction and saturate
    always_comb begin
        quo = ACC_W'(acc >>> FRAC_BITS);
        if (acc[ACC_W-1] || (acc == '0)) begin
            res = '0;
        end else if (quo > ACC_W'(PIX_MAX)) begin
            res = PIX_W'(PIX_MAX);
        end else begin
            res = quo[PIX_W-1:0];
        end
    end

endmodule

>>> src/conv3x3_clamped_filter.sv
// 3x3 clamped convolution filter, top level. An accepted input beat passes stage 1,
// the stage 2 window and the output register. Throughput: one pixel per cycle unless
// m_tready stalls, set by the single read and single write port of the line store;
// border pixels give none. Reset (aresetn low, synchronous) clears counters, pipeline
// valids and config registers to defaults; line stores are not cleared and need no
// sweep. Depends on c3f_pkg, c3f_line_buf, c3f_mac and assert_macros.svh.
`include "assert_macros.svh"

module conv3x3_clamped_filter import c3f_pkg::*; #(
    parameter int MAX_LINE       = 2048,
    parameter int COEF_FRAC_BITS = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input pixels
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // chan_zero, chan_one, chan_two
    input  logic                  s_tuser,   // frame_start
    // Filtered pixels
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // res_zero, res_one, res_two,
                                             // centre_col, centre_row, pad
    output logic                  m_tlast,   // frame_last
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_LINE);
    localparam int LIM_W  = $clog2(MAX_LINE + 1);
    localparam int CMP_W  = (LIM_W > DIM_W) ? LIM_W : DIM_W;
    localparam int LB_W   = 2 * PIX_PACK_W;

    // Configuration registers
    logic [2:0][MASK_W-1:0] mask_reg;
    logic [BIAS_W-1:0]      bias_reg;
    logic [DIM_W-1:0]       width_reg;
    logic [DIM_W-1:0]       height_reg;
    logic                   colour_reg;

    // Position counters
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [POS_W-1:0]  row_reg, row_next;

    // Stage 1: accepted pixel, line store read in flight
    logic                  s1_valid_reg;
    logic [PIX_PACK_W-1:0] s1_px_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    pos_info_t             s1_info_reg;

    // Stage 2: window holds the neighbourhood
    logic [2:0][2:0][PIX_PACK_W-1:0] win_reg;
    logic                            s2_emit_reg;
    pos_info_t                       s2_info_reg;

    // Output register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tlast_reg;

    logic              accept, s1_adv, s2_ready, out_free;
    logic [CMP_W-1:0]  w_eff, width_ext, col_ext, col_inc, col_m1;
    logic [DIM_W-1:0]  h_eff, row_ext, row_inc, row_m1;
    logic [ADDR_W-1:0] col_cur;
    logic [POS_W-1:0]  row_cur;
    pos_info_t         info_in;
    logic [LB_W-1:0]   lb_rd;

    logic [TAPS-1:0][COEF_W-1:0]           coefs;
    logic [CH_N-1:0][TAPS-1:0][PIX_W-1:0] taps;
    logic [CH_N-1:0][PIX_W-1:0]            res;

    assign cfg_ready = 1'b1;

    // Configuration write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg[0] <= '0;
            mask_reg[1] <= MASK_MID_RESET;
            mask_reg[2] <= '0;
            bias_reg    <= '0;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            colour_reg  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_MASK_TOP:     mask_reg[0] <= cfg_data[MASK_W-1:0];
                CFG_MASK_MIDDLE:  mask_reg[1] <= cfg_data[MASK_W-1:0];
                CFG_MASK_BOTTOM:  mask_reg[2] <= cfg_data[MASK_W-1:0];
                CFG_OFFSET_BIAS:  bias_reg    <= cfg_data[BIAS_W-1:0];
                CFG_FRAME_WIDTH:  width_reg   <= cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: height_reg  <= cfg_data[DIM_W-1:0];
                CFG_COLOUR_MODE:  colour_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Saturated frame geometry
    assign width_ext = CMP_W'(width_reg);
    assign w_eff = (width_ext < CMP_W'(MIN_DIM))  ? CMP_W'(MIN_DIM) :
                   (width_ext > CMP_W'(MAX_LINE)) ? CMP_W'(MAX_LINE) : width_ext;
    assign h_eff = (height_reg < DIM_W'(MIN_DIM))   ? DIM_W'(MIN_DIM) :
                   (height_reg > DIM_W'(ROW_LIMIT)) ? DIM_W'(ROW_LIMIT) : height_reg;

    // Handshake chain
    assign out_free = !m_tvalid_reg || m_tready;
    assign s2_ready = !s2_emit_reg || out_free;
    assign s1_adv   = s1_valid_reg && s2_ready;
    assign s_tready = !s1_valid_reg || s2_ready;
    assign accept   = s_tvalid && s_tready;

    // Position of the incoming beat and its successor
    assign col_cur = s_tuser ? '0 : col_reg;
    assign row_cur = s_tuser ? '0 : row_reg;
    assign col_ext = CMP_W'(col_cur);
    assign row_ext = DIM_W'(row_cur);
    assign col_inc = col_ext + CMP_W'(1);
    assign row_inc = row_ext + DIM_W'(1);
    assign col_m1  = col_ext - CMP_W'(1);
    assign row_m1  = row_ext - DIM_W'(1);

    always_comb begin
        if (col_inc >= w_eff) begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
        end else begin
            col_next = col_inc[ADDR_W-1:0];
            row_next = row_cur;
        end
    end

    always_comb begin
        info_in.emit = (col_ext >= CMP_W'(2)) && (row_ext >= DIM_W'(2)) &&
                       (col_ext < w_eff) && (row_ext < h_eff);
        info_in.last = (col_ext == w_eff - CMP_W'(1)) && (row_ext == h_eff - DIM_W'(1));
        info_in.col  = col_m1[POS_W-1:0];
        info_in.row  = row_m1[POS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line stores: upper half is the older line, lower half the previous one
    c3f_line_buf #(
        .DEPTH  (MAX_LINE),
        .DATA_W (LB_W)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data ({lb_rd[PIX_PACK_W-1:0], s1_px_reg}),
        .rd_data (lb_rd)
    );

    // Stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_px_reg   <= s_tdata;
            s1_addr_reg <= col_cur;
            s1_info_reg <= info_in;
        end
    end

    // Stage 2: shift the window once per pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_emit_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_emit_reg <= s1_adv && s1_info_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= lb_rd[LB_W-1:PIX_PACK_W];
            win_reg[1][2] <= lb_rd[PIX_PACK_W-1:0];
            win_reg[2][2] <= s1_px_reg;
            s2_info_reg   <= s1_info_reg;
        end
    end

    // Mask unpack and per-channel taps, row-major
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                coefs[r*3+k] = mask_reg[r][k*COEF_W +: COEF_W];
                for (int ch = 0; ch < CH_N; ch++) begin
                    taps[ch][r*3+k] = win_reg[r][k][ch*PIX_W +: PIX_W];
                end
            end
        end
    end

    for (genvar ch = 0; ch < CH_N; ch++) begin : g_mac
        c3f_mac #(
            .FRAC_BITS (COEF_FRAC_BITS)
        ) u_mac (
            .taps  (taps[ch]),
            .coefs (coefs),
            .bias  (bias_reg),
            .res   (res[ch])
        );
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s2_emit_reg && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_emit_reg && out_free) begin
            m_tdata_reg <= {{OUT_PAD_W{1'b0}}, s2_info_reg.row, s2_info_reg.col,
                            colour_reg ? res[2] : {PIX_W{1'b0}},
                            colour_reg ? res[1] : {PIX_W{1'b0}},
                            res[0]};
            m_tlast_reg <= s2_info_reg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks
    `ASSERT_IMPL(a_s2_blocks_s1, aclk, aresetn, s2_emit_reg && m_tvalid_reg && !m_tready, !s1_adv)
    `ASSERT_NEXT(a_accept_fills_s1, aclk, aresetn, accept, s1_valid_reg)
    `ASSERT_NEXT(a_window_held, aclk, aresetn, s2_emit_reg && m_tvalid_reg && !m_tready, s2_emit_reg && $stable(win_reg))

endmodule
